>>> rtl/anp_pkg.sv
// Shared types and character codes for the ASCII number parser.
package anp_pkg;

  // Character codes
  localparam logic [7:0] CHAR_NUL    = 8'h00;
  localparam logic [7:0] CHAR_DOLLAR = 8'h24;
  localparam logic [7:0] CHAR_0      = 8'h30;
  localparam logic [7:0] CHAR_9      = 8'h39;
  localparam logic [7:0] CHAR_UC_A   = 8'h41;
  localparam logic [7:0] CHAR_UC_F   = 8'h46;
  localparam logic [7:0] CHAR_LC_A   = 8'h61;
  localparam logic [7:0] CHAR_LC_F   = 8'h66;

  // Widths
  localparam int unsigned CharW  = 8;
  localparam int unsigned WordW  = 16;
  localparam int unsigned DigitW = 4;
  // Accumulator times base plus digit, before the overflow check
  localparam int unsigned ExtW   = WordW + DigitW;

  // Decoded digit
  typedef struct packed {
    logic              legal;
    logic [DigitW-1:0] value;
  } digit_t;

  // One parse result
  typedef struct packed {
    logic [WordW-1:0] value;
    logic             digits_ok;
    logic             fits_word;
    logic             fits_byte;
  } result_t;

endpackage

>>> rtl/anp_if.sv
// Valid/ready channel interfaces for characters and parse results.
interface anp_char_if
  import anp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [CharW-1:0] character;

  modport source (output valid, output character, input ready);
  modport sink   (input valid, input character, output ready);
endinterface

interface anp_result_if
  import anp_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [WordW-1:0] value;
  logic             digits_ok;
  logic             fits_word;
  logic             fits_byte;

  modport source (output valid, output value, output digits_ok, output fits_word,
                  output fits_byte, input ready);
  modport sink   (input valid, input value, input digits_ok, input fits_word,
                  input fits_byte, output ready);
endinterface

>>> rtl/anp_digit_dec.sv
// Decodes one ASCII character into a digit for base 10 or base 16.
module anp_digit_dec
  import anp_pkg::*;
(
  input  logic [CharW-1:0] char_i,
  input  logic             hex_i,
  output digit_t           digit_o
);

  logic [CharW-1:0] offs;

  always_comb begin
    offs    = '0;
    digit_o = '0;
    if (char_i inside {[CHAR_0:CHAR_9]}) begin
      offs          = char_i - CHAR_0;
      digit_o.legal = 1'b1;
      digit_o.value = offs[DigitW-1:0];
    end else if (hex_i && (char_i inside {[CHAR_UC_A:CHAR_UC_F]})) begin
      offs          = char_i - CHAR_UC_A + 8'd10;
      digit_o.legal = 1'b1;
      digit_o.value = offs[DigitW-1:0];
    end else if (hex_i && (char_i inside {[CHAR_LC_A:CHAR_LC_F]})) begin
      offs          = char_i - CHAR_LC_A + 8'd10;
      digit_o.legal = 1'b1;
      digit_o.value = offs[DigitW-1:0];
    end
  end

endmodule

>>> rtl/anp_accum.sv
// String state: base, digit accumulation, sticky error flags and result forming.
module anp_accum
  import anp_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [CharW-1:0] char_i,
  output result_t          result_o
);

  logic [WordW-1:0] acc_q, acc_d;
  logic             hex_q, hex_d;
  logic             first_q, first_d;
  logic             bad_q, bad_d;
  logic             big_q, big_d;

  digit_t           digit;
  logic [ExtW-1:0]  acc_ext;
  logic [ExtW-1:0]  acc_next;

  anp_digit_dec u_dec (
    .char_i  (char_i),
    .hex_i   (hex_q),
    .digit_o (digit)
  );

  // Multiply by the base as a shift-add, then add the digit
  assign acc_ext  = {{DigitW{1'b0}}, acc_q};
  assign acc_next = (hex_q ? (acc_ext << 4) : ((acc_ext << 3) + (acc_ext << 1)))
                  + {{(ExtW-DigitW){1'b0}}, digit.value};

  // Next state
  always_comb begin
    acc_d   = acc_q;
    hex_d   = hex_q;
    first_d = first_q;
    bad_d   = bad_q;
    big_d   = big_q;
    if (step_i) begin
      if (char_i == CHAR_NUL) begin
        acc_d   = '0;
        hex_d   = 1'b0;
        first_d = 1'b1;
        bad_d   = 1'b0;
        big_d   = 1'b0;
      end else if (first_q && (char_i == CHAR_DOLLAR)) begin
        hex_d   = 1'b1;
        first_d = 1'b0;
      end else begin
        first_d = 1'b0;
        if (!digit.legal) begin
          bad_d = 1'b1;
        end else if (!bad_q && !big_q) begin
          if (acc_next[ExtW-1:WordW] != '0) begin
            big_d = 1'b1;
            acc_d = '0;
          end else begin
            acc_d = acc_next[WordW-1:0];
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q   <= '0;
      hex_q   <= 1'b0;
      first_q <= 1'b1;
      bad_q   <= 1'b0;
      big_q   <= 1'b0;
    end else begin
      acc_q   <= acc_d;
      hex_q   <= hex_d;
      first_q <= first_d;
      bad_q   <= bad_d;
      big_q   <= big_d;
    end
  end

  // Result as seen by a terminator arriving now
  always_comb begin
    result_o.digits_ok = !bad_q;
    result_o.fits_word = !bad_q && !big_q;
    result_o.fits_byte = result_o.fits_word && (acc_q[WordW-1:CharW] == '0);
    result_o.value     = result_o.fits_word ? acc_q : '0;
  end

endmodule

>>> rtl/ascii_number_parser.sv
// Top level: ASCII decimal or hex string to binary, one character per transfer.
// A terminator passes the input register and then the result register before its result is offered.
// Throughput: one character per cycle, set by the input register feeding the
//   shift-add accumulator; a result waiting at the output stalls
//   only a following terminator.
// Reset: asynchronous, clears both pipeline stages and returns to decimal mode.
module ascii_number_parser
  import anp_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  anp_char_if.sink            char_i,
  anp_result_if.source        res_o
);

  logic             s1_valid_q;
  logic [CharW-1:0] s1_char_q;
  logic             s1_term;
  logic             s1_adv;
  logic             out_free;
  logic             out_valid_q;
  result_t          res_q;
  result_t          res_now;

  // Handshake between stages
  assign out_free    = !out_valid_q || res_o.ready;
  assign s1_term     = (s1_char_q == CHAR_NUL);
  assign s1_adv      = s1_valid_q && (!s1_term || out_free);
  assign char_i.ready = !s1_valid_q || s1_adv;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (char_i.ready) begin
      s1_valid_q <= char_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (char_i.valid && char_i.ready) begin
      s1_char_q <= char_i.character;
    end
  end

  anp_accum u_accum (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (s1_adv),
    .char_i   (s1_char_q),
    .result_o (res_now)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_adv && s1_term;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_term) begin
      res_q <= res_now;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.value     = res_q.value;
  assign res_o.digits_ok = res_q.digits_ok;
  assign res_o.fits_word = res_q.fits_word;
  assign res_o.fits_byte = res_q.fits_byte;

  // A new result only appears after a terminator left the input stage
  a_res_from_term: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(s1_adv && s1_term))
    else $error("result without terminator");

  // A stalled character stays in the input register
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_char_q)))
    else $error("stalled character lost");

  // Flags are nested and a value is only shown when it fits
  a_flag_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> ((!res_q.fits_byte || res_q.fits_word)
                 && (!res_q.fits_word || res_q.digits_ok)
                 && (res_q.fits_word || (res_q.value == '0))))
    else $error("inconsistent result flags");

endmodule

>>> tb/sv/tb_ascii_number_parser.sv
`timescale 1ns / 1ps
// Testbench for the ASCII number parser: directed and random strings against a parse predictor.
module tb_ascii_number_parser;
  import anp_pkg::*;

  localparam int unsigned WORD_LIMIT   = 65536;
  localparam int unsigned BYTE_LIMIT   = 256;
  localparam int unsigned TOTAL_CHARS  = 1475;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned MAX_IDLE     = 6;

  // Tracks the parse state and holds the results it predicts
  class parse_scoreboard;
    logic [WordW-1:0] acc;
    bit               hex_mode;
    bit               at_first;
    bit               bad_digit;
    bit               too_big;
    result_t          expected_results[$];
    int unsigned      errors;

    function new();
      restart();
      errors = 0;
    endfunction

    function void restart();
      acc       = '0;
      hex_mode  = 1'b0;
      at_first  = 1'b1;
      bad_digit = 1'b0;
      too_big   = 1'b0;
    endfunction

    // Digit value for the current base, -1 when illegal
    function int digit_value(logic [CharW-1:0] c);
      if (c >= CHAR_0 && c <= CHAR_9) return int'(c - CHAR_0);
      if (hex_mode && c >= CHAR_UC_A && c <= CHAR_UC_F) return int'(c - CHAR_UC_A) + 10;
      if (hex_mode && c >= CHAR_LC_A && c <= CHAR_LC_F) return int'(c - CHAR_LC_A) + 10;
      return -1;
    endfunction

    // Advance the parse by one accepted character
    function void note_char(logic [CharW-1:0] c);
      result_t     r;
      int          d;
      int unsigned grown;
      if (c == CHAR_NUL) begin
        r.digits_ok = !bad_digit;
        r.fits_word = r.digits_ok && !too_big;
        r.fits_byte = r.fits_word && (acc < BYTE_LIMIT);
        r.value     = r.fits_word ? acc : '0;
        expected_results.insert(expected_results.size(), r);
        restart();
        return;
      end
      if (at_first && c == CHAR_DOLLAR) begin
        hex_mode = 1'b1;
        at_first = 1'b0;
        return;
      end
      at_first = 1'b0;
      d = digit_value(c);
      if (d < 0) begin
        bad_digit = 1'b1;
      end else if (!bad_digit && !too_big) begin
        grown = int'(acc) * (hex_mode ? 16 : 10) + d;
        if (grown >= WORD_LIMIT) begin
          too_big = 1'b1;
          acc     = '0;
        end else begin
          acc = grown[WordW-1:0];
        end
      end
    endfunction

    function void compare_field(string name, logic [WordW-1:0] want, logic [WordW-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    // Compare one transferred result with the oldest prediction
    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got value %0h ok %b word %b byte %b",
                 $time, got.value, got.digits_ok, got.fits_word, got.fits_byte);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      compare_field("value", want.value, got.value);
      compare_field("digits_ok", WordW'(want.digits_ok), WordW'(got.digits_ok));
      compare_field("fits_word", WordW'(want.fits_word), WordW'(got.fits_word));
      compare_field("fits_byte", WordW'(want.fits_byte), WordW'(got.fits_byte));
    endfunction

    function int unsigned pending();
      return expected_results.size();
    endfunction
  endclass

  logic             clk;
  logic             rst_n;
  logic [CharW-1:0] char_q[$];
  int unsigned      chars_sent;
  int unsigned      cycles;
  bit               char_quiet;
  bit               res_quiet;
  parse_scoreboard  sb;

  anp_char_if   char_if ();
  anp_result_if res_if ();

  ascii_number_parser dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .char_i (char_if),
    .res_o  (res_if)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_ascii_number_parser: done, errors");
      $finish;
    end
  end

  // Append a string and its terminator to the character queue
  function automatic void queue_text(string s);
    for (int i = 0; i < s.len(); i++) char_q.insert(char_q.size(), s[i]);
    char_q.insert(char_q.size(), CHAR_NUL);
  endfunction

  // One character transfer, with a random gap before it
  task automatic send_char(input logic [CharW-1:0] c);
    int unsigned gap;
    if ($urandom_range(0, 63) == 0) char_quiet = !char_quiet;
    gap = char_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap > 0) begin
      char_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    char_if.valid     <= 1'b1;
    char_if.character <= c;
    do @(posedge clk); while (char_if.ready !== 1'b1);
    sb.note_char(c);
    chars_sent++;
  endtask

  task automatic send_queued();
    while (char_q.size() > 0) send_char(char_q.pop_front());
  endtask

  // Result side: random stalls, check each transfer
  initial begin : result_sink
    int unsigned gap;
    result_t     got;
    res_if.ready <= 1'b0;
    @(posedge rst_n);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 63) == 0) res_quiet = !res_quiet;
      gap = res_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (gap > 0) begin
        res_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk); while (res_if.valid !== 1'b1);
      got.value     = res_if.value;
      got.digits_ok = res_if.digits_ok;
      got.fits_word = res_if.fits_word;
      got.fits_byte = res_if.fits_byte;
      sb.check_result(got);
    end
  end

  // Stimulus
  initial begin : stimulus
    string       s;
    int unsigned num;
    int unsigned style;
    int unsigned flaw;
    int unsigned pos;
    sb = new();
    chars_sent = 0;
    char_quiet = 1'b0;
    res_quiet  = 1'b0;
    char_if.valid     <= 1'b0;
    char_if.character <= CHAR_NUL;
    rst_n             <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty, lone dollar, decimal overflow, mixed-case hex byte,
    // dollar after the first character and high characters, hex overflow
    queue_text("");
    queue_text("$");
    queue_text("65536");
    queue_text("$aF");
    queue_text("9$\377\200");
    queue_text("$10000");
    send_queued();

    // Random strings, mostly well formed, some near the word boundary
    while (chars_sent < TOTAL_CHARS) begin
      style = $urandom_range(0, 99);
      num = ($urandom_range(0, 3) == 0) ? $urandom_range(65400, 65700)
                                        : ($urandom_range(0, 99999) >> $urandom_range(0, 16));
      s = (style < 50) ? $sformatf("%0d", num) : $sformatf("%0h", num);
      if ($urandom_range(0, 7) == 0) s = {"0", s};
      // long runs can push past the word limit and keep going
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(3, 8))
          s = {s, (style < 50) ? $sformatf("%0d", $urandom_range(0, 9))
                               : $sformatf("%0h", $urandom_range(0, 15))};
      end
      if (style >= 50) begin
        for (int i = 0; i < s.len(); i++)
          if (s[i] >= "a" && $urandom_range(0, 1) == 1) s[i] = s[i] - 8'h20;
        s = {"$", s};
      end
      // corrupt some strings
      flaw = $urandom_range(0, 99);
      if (flaw < 12 && s.len() > 0) begin
        pos = $urandom_range(0, s.len() - 1);
        s[pos] = 8'($urandom_range(1, 255));
      end else if (flaw < 17) begin
        s = {s, string'(8'($urandom_range(1, 255)))};
      end else if (flaw < 21) begin
        s = "";
        repeat ($urandom_range(1, 6)) s = {s, string'(8'($urandom_range(1, 255)))};
      end else if (flaw < 25) begin
        s = ($urandom_range(0, 1) == 1) ? "$" : "";
      end
      queue_text(s);
      send_queued();
    end
    char_if.valid <= 1'b0;

    // Drain
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("tb_ascii_number_parser: done, clean");
    end else begin
      $display("tb_ascii_number_parser: done, errors");
    end
    $finish;
  end

endmodule
